>>> sv/magnitude_average_follower_macros.svh
// Assertion macros for the magnitude average follower checker.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef MAGNITUDE_AVERAGE_FOLLOWER_MACROS_SVH
`define MAGNITUDE_AVERAGE_FOLLOWER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define MAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define MAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/maf_pkg.sv
// Shared constants, types and coefficient tables for the magnitude average follower.
// No dependencies.
package maf_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int LEVEL_BITS_DEF    = 24;
  localparam int EXP_FRAC_BITS_DEF = 8;
  localparam int DECADES_W         = 12;
  localparam int ENV_W             = 15;
  localparam int COEF_BITS         = 24;
  localparam int FRAC_Q            = 30;
  localparam int MUL_DIGIT_BITS    = 8;
  localparam int DEC_ENTRIES       = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FMUL,
    ST_DMUL,
    ST_UMUL,
    ST_PUT
  } state_t;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_FRAC,
    MOP_DEC,
    MOP_UPD
  } mul_op_t;

  // 10^-k in Q1.24, rounded; decades 8 and up give zero and never get here
  function automatic logic [COEF_BITS:0] decade_coef(input logic [2:0] k);
    logic [COEF_BITS:0] v;
    case (k)
      3'd0: v = 25'd16777216;
      3'd1: v = 25'd1677722;
      3'd2: v = 25'd167772;
      3'd3: v = 25'd16777;
      3'd4: v = 25'd1678;
      3'd5: v = 25'd168;
      3'd6: v = 25'd17;
      3'd7: v = 25'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // 10^(-2^-j) in Q1.30 for fraction bit j (1 = top)
  function automatic logic [FRAC_Q:0] frac_factor(input logic [3:0] j);
    logic [FRAC_Q:0] v;
    case (j)
      4'd1:    v = 31'd339546978;
      4'd2:    v = 31'd603809400;
      4'd3:    v = 31'd805192776;
      4'd4:    v = 31'd929822112;
      4'd5:    v = 31'd999194121;
      4'd6:    v = 31'd1035797526;
      4'd7:    v = 31'd1054599037;
      4'd8:    v = 31'd1064127385;
      4'd9:    v = 31'd1068923795;
      4'd10:   v = 31'd1071330101;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

endpackage

>>> sv/maf_mul.sv
// Digit-serial multiplier: one multiplier digit per cycle, rounding addend preloaded.
// Depends on maf_pkg for the default digit width.
module maf_mul import maf_pkg::*; #(
  parameter int W     = 32,
  parameter int DIGIT = MUL_DIGIT_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  input  logic [W-1:0]   rnd,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int ND = (W + DIGIT - 1) / DIGIT;
  localparam int BW = ND * DIGIT;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;

  logic [W-1:0]       a_r;
  logic [BW-1:0]      b_r;
  logic [W:0]         hi_r;
  logic [BW-1:0]      lo_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [W+DIGIT-1:0] pp;
  logic [W+DIGIT:0]   sum;
  logic [W+BW:0]      full;
  logic               last;

  // add one partial product to the running high half
  assign pp   = a_r * b_r[DIGIT-1:0];
  assign sum  = (W + DIGIT + 1)'(hi_r) + (W + DIGIT + 1)'(pp);
  assign last = (cnt_r == CW'(ND - 1));
  assign full = {hi_r, lo_r};
  assign prod = full[2*W-1:0];
  assign done = done_r;

  // load operands, then shift one digit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= BW'(b);
      hi_r  <= (W + 1)'(rnd);
      cnt_r <= '0;
    end else if (busy_r) begin
      b_r   <= b_r >> DIGIT;
      hi_r  <= sum[W+DIGIT:DIGIT];
      lo_r  <= {sum[DIGIT-1:0], lo_r[BW-1:DIGIT]};
      cnt_r <= CW'(cnt_r + 1'b1);
    end
  end

  // track the run and pulse done after the last digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

>>> sv/magnitude_average_follower.sv
// Magnitude average follower: one-pole smoothing of a rectified audio sample.
// Input beat: in_sample (signed) and in_decades (smoothing exponent, 0.1 to this power
// is the coefficient); it is taken when in_valid is high and in_stall is low.
// Output beat: out_envelope, the top 15 bits of the level after the update, held
// on out_valid until out_stall is low.
// One item is worked at a time. A shared digit-serial multiplier (8 bits per
// cycle) carries the work: one product per set fraction bit of the exponent,
// one for the decade, one for the update. An exponent of 8 decades or more
// holds the level and goes from accept straight to the output write.
// The next beat is taken the cycle after a result is written.
// The output register lets the next beat be accepted while a result waits;
// a stalled output delays only the write of the following result.
// Reset (rst_n low, synchronous) clears the level to zero and drops out_valid.
// Depends on maf_pkg and maf_mul.
module magnitude_average_follower import maf_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
  parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic        [DECADES_W-1:0]   in_decades,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [ENV_W-1:0]       out_envelope
);

  localparam int LSH   = LEVEL_BITS - (SAMPLE_BITS - 1);
  localparam int MW    = (LEVEL_BITS > FRAC_Q + 1) ? LEVEL_BITS : FRAC_Q + 1;
  localparam int CNT_W = $clog2(EXP_FRAC_BITS + 1);
  localparam logic [MW-1:0] RND_FRAC = MW'(1) << (FRAC_Q - 1);
  localparam logic [MW-1:0] RND_COEF = MW'(1) << (COEF_BITS - 1);

  state_t                 state_r, state_nxt;
  logic [LEVEL_BITS-1:0]  level_r;
  logic [LEVEL_BITS-1:0]  m_r;
  logic [EXP_FRAC_BITS-1:0] fp_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [2:0]             ip_r;
  logic [FRAC_Q:0]        acc_r;
  logic [ENV_W-1:0]       env_r;
  logic                   out_valid_r;

  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] s_u;
  logic [SAMPLE_BITS-1:0] neg_s;
  logic [SAMPLE_BITS-2:0] mag;
  logic [LEVEL_BITS-1:0]  m_in;
  logic [DECADES_W-1:0]   ip_full;
  logic                   coef_zero;
  logic                   scan_end;
  logic                   fp_top;
  logic                   ge;
  logic [LEVEL_BITS-1:0]  d;
  logic [LEVEL_BITS-1:0]  step;
  logic [COEF_BITS:0]     c_new;
  logic                   ld_out;

  mul_op_t                mul_op;
  logic                   mul_start;
  logic [MW-1:0]          mul_a, mul_b, mul_rnd;
  logic                   mul_done;
  logic [2*MW-1:0]        mul_prod;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // rectify, saturating the most negative code
  assign s_u   = in_sample;
  assign neg_s = ~s_u + 1'b1;
  always_comb begin
    if (!s_u[SAMPLE_BITS-1]) begin
      mag = s_u[SAMPLE_BITS-2:0];
    end else if (neg_s[SAMPLE_BITS-1]) begin
      mag = '1;
    end else begin
      mag = neg_s[SAMPLE_BITS-2:0];
    end
  end

  // align the magnitude to the level's scale
  generate
    if (LSH >= 0) begin : g_up
      assign m_in = LEVEL_BITS'(mag) << LSH;
    end else begin : g_down
      assign m_in = LEVEL_BITS'(mag >> (-LSH));
    end
  endgenerate

  assign ip_full   = in_decades >> EXP_FRAC_BITS;
  assign coef_zero = (ip_full > DECADES_W'(DEC_ENTRIES - 1));
  assign scan_end  = (cnt_r == CNT_W'(EXP_FRAC_BITS));
  assign fp_top    = fp_r[EXP_FRAC_BITS-1];

  // distance and direction toward the magnitude
  assign ge    = (m_r >= level_r);
  assign d     = ge ? (m_r - level_r) : (level_r - m_r);
  assign c_new = mul_prod[FRAC_Q +: COEF_BITS+1];
  assign step  = mul_prod[COEF_BITS +: LEVEL_BITS];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = coef_zero ? ST_PUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DMUL;
        end else if (fp_top) begin
          state_nxt = ST_FMUL;
        end
      end
      ST_FMUL: if (mul_done) state_nxt = ST_SCAN;
      ST_DMUL: if (mul_done) state_nxt = ST_UMUL;
      ST_UMUL: if (mul_done) state_nxt = ST_PUT;
      ST_PUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier launches and output load
  always_comb begin
    mul_op    = MOP_NONE;
    mul_start = 1'b0;
    ld_out    = 1'b0;
    unique case (state_r)
      ST_SCAN: begin
        if (scan_end) begin
          mul_op    = MOP_DEC;
          mul_start = 1'b1;
        end else if (fp_top) begin
          mul_op    = MOP_FRAC;
          mul_start = 1'b1;
        end
      end
      ST_DMUL: begin
        if (mul_done) begin
          mul_op    = MOP_UPD;
          mul_start = 1'b1;
        end
      end
      ST_PUT:  ld_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // select multiplier operands
  always_comb begin
    case (mul_op)
      MOP_FRAC: begin
        mul_a   = MW'(acc_r);
        mul_b   = MW'(frac_factor(4'(cnt_r) + 4'd1));
        mul_rnd = RND_FRAC;
      end
      MOP_DEC: begin
        mul_a   = MW'(acc_r);
        mul_b   = MW'(decade_coef(ip_r));
        mul_rnd = RND_FRAC;
      end
      MOP_UPD: begin
        mul_a   = MW'(d);
        mul_b   = MW'(c_new);
        mul_rnd = RND_COEF;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_rnd = '0;
      end
    endcase
  end

  maf_mul #(
    .W     (MW),
    .DIGIT (MUL_DIGIT_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .rnd   (mul_rnd),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // capture the beat and walk the fraction bits from the top
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      m_r   <= m_in;
      fp_r  <= in_decades[EXP_FRAC_BITS-1:0];
      cnt_r <= '0;
      ip_r  <= ip_full[2:0];
      acc_r <= (FRAC_Q + 1)'(1) << FRAC_Q;
    end else if (state_r == ST_SCAN && !scan_end && !fp_top) begin
      fp_r  <= fp_r << 1;
      cnt_r <= CNT_W'(cnt_r + 1'b1);
    end else if (state_r == ST_FMUL && mul_done) begin
      acc_r <= mul_prod[FRAC_Q +: FRAC_Q+1];
      fp_r  <= fp_r << 1;
      cnt_r <= CNT_W'(cnt_r + 1'b1);
    end
  end

  // hold the output beat
  always_ff @(posedge clk) begin
    if (ld_out) begin
      env_r <= level_r[LEVEL_BITS-1 -: ENV_W];
    end
  end

  // state, level and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UMUL && mul_done) begin
        level_r <= ge ? (level_r + step) : (level_r - step);
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_envelope = env_r;

endmodule

>>> sv/maf_checker.sv
// Port-level checks for the magnitude average follower, bound to the top level.
// Depends on maf_pkg and the assertion macros header.
`include "magnitude_average_follower_macros.svh"

module maf_prop_checker import maf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [SAMPLE_BITS-1:0] in_sample,
  input logic        [DECADES_W-1:0]   in_decades,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic        [ENV_W-1:0]       out_envelope
);

  // a stalled result stays put
  `MAF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_envelope), "stalled output beat changed")

  // one item at a time: an accepted beat closes the input
  `MAF_ASSERT_NEXT(a_in_close, in_valid && !in_stall, in_stall, "input open right after accept")

  // a new result is written only while the input is closed
  `MAF_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(in_stall), "result appeared without work")

endmodule

bind magnitude_average_follower maf_prop_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_maf_prop_checker (.*);

>>> verif/maf_checker.sv
// Scoreboard for the magnitude average follower: watches both channels, keeps its
// own level register and envelope predictor, and compares every output beat.
// Depends on maf_pkg for widths only.
module maf_checker import maf_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample,
  input  logic        [DECADES_W-1:0]       in_decades,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic        [ENV_W-1:0]           out_envelope,
  output int                                mismatches,
  output int                                outstanding
);

  localparam int MAG_SHIFT = LEVEL_BITS_DEF - (SAMPLE_BITS_DEF - 1);

  logic [LEVEL_BITS_DEF-1:0] follow_level;
  logic [ENV_W-1:0]          envelope_q[$];

  // 0.1 ^ (dec / 2^frac) in Q1.24: fraction powers in Q1.30 first, then the decade
  function automatic logic [COEF_BITS:0] smoothing_coef(input logic [DECADES_W-1:0] dec);
    longint unsigned acc;
    longint unsigned pow;
    longint unsigned decade_unit;
    acc = 64'd1 << FRAC_Q;
    for (int b = EXP_FRAC_BITS_DEF - 1; b >= 0; b--) begin
      if (dec[b]) begin
        case (EXP_FRAC_BITS_DEF - b)
          1:       pow = 64'd339546978;
          2:       pow = 64'd603809400;
          3:       pow = 64'd805192776;
          4:       pow = 64'd929822112;
          5:       pow = 64'd999194121;
          6:       pow = 64'd1035797526;
          7:       pow = 64'd1054599037;
          8:       pow = 64'd1064127385;
          default: pow = 64'd1073741824;
        endcase
        acc = (acc * pow + (64'd1 << (FRAC_Q - 1))) >> FRAC_Q;
      end
    end
    // integer part 8 and above is below resolution
    case (dec[DECADES_W-1:EXP_FRAC_BITS_DEF])
      4'd0:    decade_unit = 64'd16777216;
      4'd1:    decade_unit = 64'd1677722;
      4'd2:    decade_unit = 64'd167772;
      4'd3:    decade_unit = 64'd16777;
      4'd4:    decade_unit = 64'd1678;
      4'd5:    decade_unit = 64'd168;
      4'd6:    decade_unit = 64'd17;
      4'd7:    decade_unit = 64'd2;
      default: decade_unit = 64'd0;
    endcase
    return (decade_unit * acc + (64'd1 << (FRAC_Q - 1))) >> FRAC_Q;
  endfunction

  // Rectify, move the level toward the magnitude, return the new envelope
  function automatic logic [ENV_W-1:0] follow_step(input logic signed [SAMPLE_BITS_DEF-1:0] s,
                                                   input logic [DECADES_W-1:0] dec);
    logic [SAMPLE_BITS_DEF-2:0] mag;
    longint unsigned target;
    longint unsigned lvl;
    longint unsigned coef;
    longint unsigned gap;
    longint unsigned step;
    // saturate the most negative sample
    if (s == {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}})
      mag = '1;
    else if (s < 0)
      mag = (SAMPLE_BITS_DEF-1)'(-s);
    else
      mag = s[SAMPLE_BITS_DEF-2:0];
    target = 64'(mag) << MAG_SHIFT;
    lvl    = 64'(follow_level);
    coef   = 64'(smoothing_coef(dec));
    if (target >= lvl) begin
      gap  = target - lvl;
      step = (coef * gap + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
      lvl  = lvl + step;
    end else begin
      gap  = lvl - target;
      step = (coef * gap + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
      lvl  = lvl - step;
    end
    follow_level = lvl[LEVEL_BITS_DEF-1:0];
    return follow_level[LEVEL_BITS_DEF-1 -: ENV_W];
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Predict on each input beat, compare on each output beat
  always @(posedge clk) begin : watch
    logic [ENV_W-1:0] want;
    if (!rst_n) begin
      follow_level = '0;
      envelope_q.delete();
      mismatches   = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall)
        envelope_q.push_back(follow_step(in_sample, in_decades));
      if (out_valid && !out_stall) begin
        if (envelope_q.size() == 0) begin
          report_mismatch("unexpected envelope beat", -1, int'(out_envelope));
        end else begin
          want = envelope_q.pop_front();
          if (out_envelope !== want)
            report_mismatch("envelope", int'(want), int'(out_envelope));
        end
      end
      outstanding <= envelope_q.size();
    end
  end

endmodule

>>> verif/testbench.sv
// Top of the magnitude average follower testbench: clock, reset, beat stimulus,
// output stall pattern, watchdog and verdict.
// Depends on maf_pkg, magnitude_average_follower and maf_checker.
module testbench;
  import maf_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 80;
  localparam int RANDOM_BEATS = 460;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_valid   = 1'b0;
  logic signed [SAMPLE_BITS_DEF-1:0] in_sample  = '0;
  logic        [DECADES_W-1:0]       in_decades = '0;
  logic                              out_stall  = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  logic        [ENV_W-1:0]           out_envelope;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int mismatches;
  int outstanding;

  magnitude_average_follower u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_decades   (in_decades),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_envelope (out_envelope)
  );

  maf_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_decades   (in_decades),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_envelope (out_envelope),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the output at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Drive one input beat, idling first at random, and wait until it is taken
  task automatic put_beat(input logic signed [SAMPLE_BITS_DEF-1:0] s,
                          input logic [DECADES_W-1:0] d);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= s;
    in_decades <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every predicted envelope has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic signed [SAMPLE_BITS_DEF-1:0] s;
    logic        [DECADES_W-1:0]       d;
    int                                pick;
    s = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, saturation, jump, hold and both directions
    send_gap_pct = 14;
    stall_pct    = 57;
    put_beat(16'sh7FFF, 12'h000);
    put_beat(16'sh8000, 12'h000);
    put_beat(16'sh0000, 12'h000);
    put_beat(-16'sd1,   12'h000);
    put_beat(16'sh7FFF, 12'h100);
    put_beat(16'sh7FFF, 12'h0FF);
    put_beat(16'sh7FFF, 12'h080);
    put_beat(16'sh0000, 12'h001);
    put_beat(16'sh0000, 12'h800);
    put_beat(16'sh8000, 12'hFFF);
    put_beat(16'sh7FFF, 12'h700);
    put_beat(16'sh7FFF, 12'h7FF);
    put_beat(16'sh7FFF, 12'h600);
    put_beat(16'sh5555, 12'hAAA);
    put_beat(16'shAAAA, 12'h155);
    put_beat(16'sh4000, 12'h200);
    put_beat(16'shC000, 12'h000);
    put_beat(16'sh0001, 12'h300);
    drain();

    // Random: receiver-heavy stalling, then sender-heavy idling, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 14; stall_pct = 57; end
        1:       begin send_gap_pct = 57; stall_pct = 14; end
        default: begin send_gap_pct = 0;  stall_pct = 0;  end
      endcase
      repeat (RANDOM_BEATS) begin
        // keep the last sample 17 percent of the time so the level can settle
        pick = $urandom_range(99);
        if (pick < 8)
          s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else if (pick >= 25)
          s = SAMPLE_BITS_DEF'($urandom);
        // favor fast coefficients, with some slow, held and full-range ones
        pick = $urandom_range(99);
        if (pick < 55)
          d = {4'($urandom_range(2)), 8'($urandom)};
        else if (pick < 80)
          d = {4'($urandom_range(7)), 8'($urandom)};
        else if (pick < 90)
          d = DECADES_W'($urandom);
        else if (pick < 95)
          d = '0;
        else
          d = {4'($urandom_range(15, 8)), 8'($urandom)};
        put_beat(s, d);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
